/* src/line_pixel_generator_defines.svh */
// ----------------------------------------------------------------------------
// Line pixel generator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line pixel generator check failed");

// Next-cycle implication, disabled during reset.
`define LPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line pixel generator check failed");

// Next-cycle implication that also holds across reset.
`define LPG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("line pixel generator reset check failed");

`endif

/* src/lpg_pkg.sv */
// ----------------------------------------------------------------------------
// Line pixel generator package
// Shared constants, queue entry type and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpg_pkg;

  localparam int LPG_MAX_DIM     = 4096;
  localparam int LPG_FRAC_BITS   = 16;
  localparam int LPG_COORD_W     = 15;
  localparam int LPG_CFG_W       = 13;
  localparam int LPG_DIM_W       = 15;
  localparam int LPG_COLOR_W     = 32;
  localparam int LPG_ADDR_W      = 24;
  localparam int LPG_ACC_W       = 32;
  localparam int LPG_QUEUE_DEPTH = 2;
  localparam int LPG_RESET_WIDTH  = 640;
  localparam int LPG_RESET_HEIGHT = 480;

  typedef enum logic [0:0] {
    LPG_REG_CANVAS_WIDTH,
    LPG_REG_CANVAS_HEIGHT
  } lpg_reg_t;

  typedef enum logic [0:0] {
    LPG_ACT_LINE,
    LPG_ACT_TICK
  } lpg_action_t;

  typedef enum logic {
    LPG_ST_RUN,
    LPG_ST_DIV
  } lpg_state_t;

  typedef struct packed {
    lpg_action_t                    action;
    logic                           y_major;
    logic                           step_down;
    logic signed [LPG_COORD_W-1:0]  major_start;
    logic signed [LPG_COORD_W-1:0]  major_end;
    logic signed [LPG_COORD_W-1:0]  minor_start;
    logic [LPG_COORD_W-1:0]         num_mag;
    logic [LPG_COORD_W-1:0]         den_mag;
    logic                           neg;
    logic [LPG_COLOR_W-1:0]         color;
  } lpg_entry_t;

endpackage

/* src/lpg_front.sv */
// ----------------------------------------------------------------------------
// Line pixel generator front end
// Accepts input transfers and classifies line commands by major axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpg_front import lpg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [95:0]      s_axis_tdata,  // start_x, start_y, end_x, end_y, line_color, pad
  input  logic             s_axis_tuser,  // action
  input  logic             full,
  output logic             push,
  output lpg_entry_t       entry
);

  logic signed [LPG_COORD_W-1:0] x0, y0, x1, y1;
  logic signed [LPG_COORD_W:0]   dx, dy, dmaj, dmin;
  logic [LPG_COORD_W-1:0]        adx, ady;
  logic                          ymaj;
  logic                          busy;

  assign x0 = s_axis_tdata[14:0];
  assign y0 = s_axis_tdata[29:15];
  assign x1 = s_axis_tdata[44:30];
  assign y1 = s_axis_tdata[59:45];

  assign dx  = {x1[LPG_COORD_W-1], x1} - {x0[LPG_COORD_W-1], x0};
  assign dy  = {y1[LPG_COORD_W-1], y1} - {y0[LPG_COORD_W-1], y0};
  assign adx = dx[LPG_COORD_W] ? LPG_COORD_W'(-dx) : LPG_COORD_W'(dx);
  assign ady = dy[LPG_COORD_W] ? LPG_COORD_W'(-dy) : LPG_COORD_W'(dy);
  assign ymaj = ady > adx;
  assign dmaj = ymaj ? dy : dx;
  assign dmin = ymaj ? dx : dy;

  // hold off input until reset has been seen once
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign s_axis_tready = !full && !busy;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    entry.action      = lpg_action_t'(s_axis_tuser);
    entry.y_major     = ymaj;
    entry.step_down   = dmaj[LPG_COORD_W] || (dmaj == '0);
    entry.major_start = ymaj ? y0 : x0;
    entry.major_end   = ymaj ? y1 : x1;
    entry.minor_start = ymaj ? x0 : y0;
    entry.num_mag     = ymaj ? adx : ady;
    entry.den_mag     = ymaj ? ady : adx;
    entry.neg         = dmaj[LPG_COORD_W] ^ dmin[LPG_COORD_W];
    entry.color       = s_axis_tdata[91:60];
  end

endmodule

/* src/lpg_queue.sv */
// ----------------------------------------------------------------------------
// Line pixel generator queue
// Short FIFO of classified items between front end and sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpg_queue import lpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lpg_entry_t wr_entry,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output lpg_entry_t rd_entry
);

  localparam int PTR_W = $clog2(LPG_QUEUE_DEPTH);

  lpg_entry_t         slots [LPG_QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full      = count == (PTR_W+1)'(LPG_QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

/* src/lpg_back.sv */
// ----------------------------------------------------------------------------
// Line pixel generator sequencer
// Holds the active line, runs the slope divider and emits pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpg_back import lpg_pkg::*; #(
  parameter int MAX_DIM   = LPG_MAX_DIM,
  parameter int FRAC_BITS = LPG_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  lpg_entry_t           q_entry,
  output logic                 pop,
  input  logic [LPG_CFG_W-1:0] canvas_width,
  input  logic [LPG_CFG_W-1:0] canvas_height,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [87:0]          m_axis_tdata,  // pixel_x, pixel_y, pixel_address, pixel_color, pad
  output logic                 m_axis_tuser,  // visible
  output logic                 m_axis_tlast
);

  localparam int NUM_W = LPG_COORD_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [LPG_DIM_W-1:0] DIM_MAX = LPG_DIM_W'(MAX_DIM);

  lpg_state_t state, state_next;

  logic                          line_active;
  logic                          y_major;
  logic                          step_down;
  logic signed [LPG_COORD_W-1:0] major_pos;
  logic signed [LPG_COORD_W-1:0] major_end;
  logic [LPG_ACC_W-1:0]          acc;
  logic [LPG_ACC_W-1:0]          inc;
  logic [LPG_COLOR_W-1:0]        color;

  logic [LPG_COORD_W-1:0] rem;
  logic [LPG_COORD_W-1:0] den;
  logic [NUM_W-1:0]       num;
  logic [NUM_W-1:0]       quo;
  logic                   neg;
  logic [CNT_W-1:0]       cnt;

  logic [LPG_COORD_W:0]   partial;
  logic                   ge;
  logic [LPG_COORD_W:0]   diff;
  logic [NUM_W-1:0]       q_fin;
  logic [LPG_ACC_W-1:0]   q_ext;
  logic                   div_done;

  logic [LPG_COORD_W-1:0] minor, px, py;
  logic [LPG_DIM_W-1:0]   w, h;
  logic                   vis;
  logic [28:0]            prod;
  logic                   last;
  logic                   slot_free;
  logic                   is_tick;

  logic [LPG_COORD_W-1:0] ox, oy;
  logic                   ovis;
  logic [LPG_ADDR_W-1:0]  oaddr;
  logic [LPG_COLOR_W-1:0] ocolor;
  logic                   olast;

  // divider step
  assign partial  = {rem, num[NUM_W-1]};
  assign ge       = partial >= {1'b0, den};
  assign diff     = partial - {1'b0, den};
  assign q_fin    = {quo[NUM_W-2:0], ge};
  assign q_ext    = LPG_ACC_W'(q_fin);
  assign div_done = cnt == CNT_W'(NUM_W - 1);

  // pixel of the current position
  assign minor = acc[FRAC_BITS +: LPG_COORD_W];
  assign px    = y_major ? minor : major_pos;
  assign py    = y_major ? major_pos : minor;
  assign w     = ({2'b00, canvas_width}  > DIM_MAX) ? DIM_MAX : {2'b00, canvas_width};
  assign h     = ({2'b00, canvas_height} > DIM_MAX) ? DIM_MAX : {2'b00, canvas_height};
  assign vis   = !px[LPG_COORD_W-1] && !py[LPG_COORD_W-1]
                 && ({1'b0, px} < {1'b0, w}) && ({1'b0, py} < {1'b0, h});
  assign prod  = 29'(py[LPG_COORD_W-2:0]) * 29'(w) + 29'(px[LPG_COORD_W-2:0]);
  assign last  = major_pos == major_end;

  assign is_tick   = q_entry.action == LPG_ACT_TICK;
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      LPG_ST_RUN: begin
        if (q_valid && (!is_tick || slot_free)) begin
          pop = 1'b1;
          if (!is_tick && q_entry.den_mag != '0) begin
            state_next = LPG_ST_DIV;
          end
        end
      end
      LPG_ST_DIV: begin
        if (div_done) begin
          state_next = LPG_ST_RUN;
        end
      end
      default: begin
        state_next = LPG_ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= LPG_ST_RUN;
      line_active <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && !is_tick) begin
        line_active <= 1'b1;
      end else if (pop && line_active && last) begin
        line_active <= 1'b0;
      end
      if (pop && is_tick && line_active) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // line state and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      y_major   <= 1'b0;
      step_down <= 1'b0;
      major_pos <= '0;
      major_end <= '0;
      acc       <= '0;
      inc       <= '0;
      color     <= '0;
    end else if (pop && !is_tick) begin
      y_major   <= q_entry.y_major;
      step_down <= q_entry.step_down;
      major_pos <= q_entry.major_start;
      major_end <= q_entry.major_end;
      acc       <= ({{(LPG_ACC_W-LPG_COORD_W){q_entry.minor_start[LPG_COORD_W-1]}},
                     q_entry.minor_start} << FRAC_BITS)
                   + (LPG_ACC_W'(1) << (FRAC_BITS - 1));
      inc       <= '0;
      color     <= q_entry.color;
    end else if (state == LPG_ST_DIV && div_done) begin
      inc <= neg ? (~q_ext + LPG_ACC_W'(1)) : q_ext;
    end else if (pop && line_active && !last) begin
      if (step_down) begin
        major_pos <= major_pos - LPG_COORD_W'(1);
        acc       <= acc - inc;
      end else begin
        major_pos <= major_pos + LPG_COORD_W'(1);
        acc       <= acc + inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !is_tick) begin
      rem <= '0;
      den <= q_entry.den_mag;
      num <= NUM_W'(q_entry.num_mag) << FRAC_BITS;
      quo <= '0;
      neg <= q_entry.neg;
      cnt <= '0;
    end else if (state == LPG_ST_DIV) begin
      rem <= ge ? diff[LPG_COORD_W-1:0] : partial[LPG_COORD_W-1:0];
      num <= num << 1;
      quo <= q_fin;
      cnt <= cnt + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (pop && is_tick && line_active) begin
      ox     <= px;
      oy     <= py;
      ovis   <= vis;
      oaddr  <= vis ? prod[LPG_ADDR_W-1:0] : '0;
      ocolor <= color;
      olast  <= last;
    end
  end

  assign m_axis_tdata = {2'b00, ocolor, oaddr, oy, ox};
  assign m_axis_tuser = ovis;
  assign m_axis_tlast = olast;

endmodule

/* src/line_pixel_generator.sv */
// ----------------------------------------------------------------------------
// Line pixel generator
// Fixed-point line rasterizer emitting one pixel per tick transfer of an active line.
// ----------------------------------------------------------------------------
// Input stream: tuser selects the action. A line command (tuser 0) carries
// both endpoints and a color in tdata and produces no output; it replaces any
// active line. A tick (tuser 1) emits the next pixel of the active line on the
// output stream, with visible in tuser and the final pixel marked by tlast; a
// tick with no active line produces nothing.
// Ticks sustain one per cycle while the output is not stalled and no slope
// division runs; a tick passes through the queue and its pixel through the
// output register. A line command whose major extent is nonzero occupies the
// sequencer in the bit-serial slope divider; the two-entry queue takes up to
// two more transfers while it runs, then the input stalls until the divider finishes.
// The config channel writes canvas_width (index 0) or canvas_height
// (index 1) and is always ready; write only while the block is idle.
// Reset: synchronous, clears the active line, sets a 640 x 480 canvas and
// holds the input off during reset and in the cycle after it.
// When the output stalls, the held pixel stays and ticks back up in the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_generator import lpg_pkg::*; #(
  parameter int MAX_DIM   = LPG_MAX_DIM,
  parameter int FRAC_BITS = LPG_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,  // start_x, start_y, end_x, end_y, line_color, pad
  input  logic                 s_axis_tuser,  // action
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [87:0]          m_axis_tdata,  // pixel_x, pixel_y, pixel_address, pixel_color, pad
  output logic                 m_axis_tuser,  // visible
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [LPG_CFG_W-1:0] cfg_data
);

  logic [LPG_CFG_W-1:0] canvas_width;
  logic [LPG_CFG_W-1:0] canvas_height;

  logic       push;
  logic       full;
  logic       q_valid;
  logic       pop;
  lpg_entry_t wr_entry;
  lpg_entry_t rd_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= LPG_CFG_W'(LPG_RESET_WIDTH);
      canvas_height <= LPG_CFG_W'(LPG_RESET_HEIGHT);
    end else if (cfg_valid) begin
      case (lpg_reg_t'(cfg_index))
        LPG_REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        LPG_REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lpg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full          (full),
    .push          (push),
    .entry         (wr_entry)
  );

  lpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .full      (full),
    .not_empty (q_valid),
    .rd_entry  (rd_entry)
  );

  lpg_back #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (rd_entry),
    .pop           (pop),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* src/lpg_checker.sv */
// ----------------------------------------------------------------------------
// Line pixel generator port checker
// Watches the top-level ports over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_pixel_generator_defines.svh"

module lpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `LPG_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `LPG_ASSERT_NOW(a_hidden_addr_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[53:30] == 24'd0)
  `LPG_ASSERT_NOW(a_visible_nonneg, clk, rst, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[14] && !m_axis_tdata[29])
  `LPG_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !m_axis_tvalid && !s_axis_tready)

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (.*);

/* sim/line_pixel_generator_checker.sv */
// ----------------------------------------------------------------------------
// Line pixel generator checker
// Follows the config, input and output streams of the rasterizer and
// predicts every pixel from its own copy of the line walker. Each output
// transfer is compared field by field with the oldest predicted pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_generator_checker import lpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [87:0]          m_axis_tdata,
  input  logic                 m_axis_tuser,
  input  logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [LPG_CFG_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   pixel_count
);

  typedef struct {
    logic [LPG_COORD_W-1:0] x;
    logic [LPG_COORD_W-1:0] y;
    logic                   visible;
    logic [LPG_ADDR_W-1:0]  addr;
    logic [LPG_COLOR_W-1:0] color;
    logic                   last;
  } pixel_t;

  pixel_t                 predicted_pixels[$];

  logic [LPG_CFG_W-1:0]   width_reg;
  logic [LPG_CFG_W-1:0]   height_reg;
  logic                   walking;
  logic                   y_major;
  logic                   step_down;
  int                     major_pos;
  int                     major_stop;
  logic [LPG_ACC_W-1:0]   minor_acc;
  logic [LPG_ACC_W-1:0]   minor_step;
  logic [LPG_COLOR_W-1:0] color_hold;

  initial begin
    fail_count  = 0;
    pending     = 0;
    pixel_count = 0;
  end

  function automatic int to_coord(logic [LPG_COORD_W-1:0] v);
    logic signed [LPG_COORD_W-1:0] s;
    s = v;
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR pixel %0d: %s", pixel_count, msg);
    fail_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
  endtask

  task automatic start_line(logic [95:0] d);
    int          x0, y0, x1, y1;
    int          d_minor, d_major, a_minor, a_major, tmp, m_start;
    longint      quot;
    logic [31:0] ms_bits;
    x0 = to_coord(d[14:0]);
    y0 = to_coord(d[29:15]);
    x1 = to_coord(d[44:30]);
    y1 = to_coord(d[59:45]);
    d_minor = y1 - y0;
    d_major = x1 - x0;
    a_minor = d_minor < 0 ? -d_minor : d_minor;
    a_major = d_major < 0 ? -d_major : d_major;
    y_major = a_minor > a_major;
    if (y_major) begin
      tmp = d_minor;
      d_minor = d_major;
      d_major = tmp;
      major_pos = y0;
      m_start = x0;
    end else begin
      major_pos = x0;
      m_start = y0;
    end
    quot = 0;
    if (d_major != 0)
      quot = (longint'(d_minor) <<< LPG_FRAC_BITS) / longint'(d_major);
    step_down  = d_major <= 0;
    major_stop = major_pos + d_major;
    minor_step = quot[LPG_ACC_W-1:0];
    ms_bits    = m_start;
    minor_acc  = (ms_bits << LPG_FRAC_BITS) + (32'h1 << (LPG_FRAC_BITS - 1));
    color_hold = d[91:60];
    walking    = 1'b1;
  endtask

  task automatic emit_pixel();
    logic signed [LPG_ACC_W-1:0] acc_s;
    logic [LPG_COORD_W-1:0]      minor_bits;
    int                          px, py, w, h;
    pixel_t                      p;
    if (!walking)
      return;
    acc_s = minor_acc;
    acc_s = acc_s >>> LPG_FRAC_BITS;
    minor_bits = acc_s[LPG_COORD_W-1:0];
    p.x = y_major ? minor_bits : major_pos[LPG_COORD_W-1:0];
    p.y = y_major ? major_pos[LPG_COORD_W-1:0] : minor_bits;
    px = to_coord(p.x);
    py = to_coord(p.y);
    w = int'(width_reg);
    h = int'(height_reg);
    if (w > LPG_MAX_DIM)
      w = LPG_MAX_DIM;
    if (h > LPG_MAX_DIM)
      h = LPG_MAX_DIM;
    p.visible = px >= 0 && py >= 0 && px < w && py < h;
    p.addr    = p.visible ? LPG_ADDR_W'(py * w + px) : '0;
    p.color   = color_hold;
    p.last    = major_pos == major_stop;
    predicted_pixels.push_back(p);
    if (p.last) begin
      walking = 1'b0;
    end else if (step_down) begin
      major_pos--;
      minor_acc = minor_acc - minor_step;
    end else begin
      major_pos++;
      minor_acc = minor_acc + minor_step;
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (predicted_pixels.size() == 0) begin
      report_mismatch("output transfer with no pixel predicted");
      pixel_count++;
      return;
    end
    want = predicted_pixels.pop_front();
    compare_field("pixel_x", 32'(m_axis_tdata[14:0]), 32'(want.x));
    compare_field("pixel_y", 32'(m_axis_tdata[29:15]), 32'(want.y));
    compare_field("pixel_address", 32'(m_axis_tdata[53:30]), 32'(want.addr));
    compare_field("pixel_color", m_axis_tdata[85:54], want.color);
    compare_field("visible", 32'(m_axis_tuser), 32'(want.visible));
    compare_field("last_pixel", 32'(m_axis_tlast), 32'(want.last));
    pixel_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = LPG_CFG_W'(LPG_RESET_WIDTH);
      height_reg = LPG_CFG_W'(LPG_RESET_HEIGHT);
      walking    = 1'b0;
      y_major    = 1'b0;
      step_down  = 1'b0;
      major_pos  = 0;
      major_stop = 0;
      minor_acc  = '0;
      minor_step = '0;
      color_hold = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (lpg_reg_t'(cfg_index) == LPG_REG_CANVAS_WIDTH)
          width_reg = cfg_data;
        else
          height_reg = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (lpg_action_t'(s_axis_tuser) == LPG_ACT_LINE)
          start_line(s_axis_tdata);
        else
          emit_pixel();
      end
      if (m_axis_tvalid && m_axis_tready)
        check_pixel();
    end
    pending = predicted_pixels.size();
  end

endmodule

/* sim/line_pixel_generator_tb.sv */
// ----------------------------------------------------------------------------
// Line pixel generator testbench
// Drives line commands and ticks into the rasterizer across several canvas
// sizes, including zero, one pixel, the maximum and oversized values, with
// random gaps on the input, random stalls on the output and a long output
// hold-off. The checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_generator_tb;
  import lpg_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [95:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [87:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [0:0]           cfg_index = '0;
  logic [LPG_CFG_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int pixel_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int canvas_w = LPG_RESET_WIDTH;
  int line_count = 0;
  int tick_count = 0;

  always #6 clk = ~clk;

  line_pixel_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  line_pixel_generator_checker pixel_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .pixel_count   (pixel_count)
  );

  // hold the output off while a long stall is pending, else stall at random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(lpg_action_t act, logic [95:0] data);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
  endtask

  task automatic draw(int x0, int y0, int x1, int y1, logic [31:0] color, int ticks);
    send_item(LPG_ACT_LINE, {4'b0, color, y1[14:0], x1[14:0], y0[14:0], x0[14:0]});
    line_count++;
    repeat (ticks) begin
      send_item(LPG_ACT_TICK, {4'b0, 32'($urandom), 32'($urandom), 28'($urandom)});
      tick_count++;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(lpg_reg_t idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[LPG_CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_canvas(int w, int h);
    drain();
    write_reg(LPG_REG_CANVAS_WIDTH, w);
    write_reg(LPG_REG_CANVAS_HEIGHT, h);
    canvas_w = w > LPG_MAX_DIM ? LPG_MAX_DIM : w;
  endtask

  function automatic int clip_coord(int v);
    if (v < -16384)
      return -16384;
    if (v > 16383)
      return 16383;
    return v;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(9) == 0)
      return int'($urandom_range(32767)) - 16384;
    return int'($urandom_range(canvas_w + 40)) - 20;
  endfunction

  function automatic int rand_end(int start);
    case ($urandom_range(9))
      0: return int'($urandom_range(32767)) - 16384;
      1: return start;
      default: return clip_coord(start + int'($urandom_range(48)) - 24);
    endcase
  endfunction

  task automatic random_lines(int n_items);
    int sent, x0, y0, x1, y1, dx, dy, len, ticks;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 6) begin
        send_item(LPG_ACT_TICK, {4'b0, 32'($urandom), 32'($urandom), 28'($urandom)});
        tick_count++;
        sent++;
      end else begin
        x0 = rand_coord();
        y0 = rand_coord();
        x1 = rand_end(x0);
        y1 = rand_end(y0);
        dx = x1 > x0 ? x1 - x0 : x0 - x1;
        dy = y1 > y0 ? y1 - y0 : y0 - y1;
        len = (dx > dy ? dx : dy) + 1;
        ticks = len > 48 ? 48 : len;
        case ($urandom_range(9))
          0: ticks = $urandom_range(ticks);
          1: ticks = ticks + $urandom_range(1, 3);
          default: ;
        endcase
        draw(x0, y0, x1, y1, $urandom, ticks);
        sent += ticks + 1;
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: reset canvas, idle tick, zero length, extremes, replace, x-major and y-major octants
    send_item(LPG_ACT_TICK, '0);
    tick_count++;
    draw(0, 0, 0, 0, 32'hFFFF_FFFF, 2);
    draw(-16384, -16384, 16383, 16383, 32'h0000_0000, 1);
    draw(16383, 16383, -16384, -16384, 32'hA5A5_5A5A, 1);
    draw(10, 10, 12, 14, 32'h1234_5678, 5);
    draw(5, 5, 1, 3, 32'h8000_0001, 5);
    draw(0, 0, -3, 3, 32'h7FFF_FFFE, 4);

    set_canvas(0, 0);
    random_lines(40);

    set_canvas(4096, 4096);
    random_lines(180);

    set_canvas(8191, 8191);
    idle_pct = 71;
    random_lines(200);

    set_canvas(1, 1);
    idle_pct = 0;
    stall_pct = 71;
    random_lines(120);

    set_canvas(100, 60);
    idle_pct = 14;
    stall_pct = 14;
    random_lines(200);

    // long output hold-off while ticks keep coming, so the input backs up
    set_canvas(640, 480);
    idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_left = 150;
    draw(-5, 2, 400, 37, $urandom, 200);
    drain();

    $display("Covered %0d line commands and %0d ticks over six canvas settings.",
             line_count, tick_count);
    $display("Checked %0d pixels under input gaps, output stalls and a long hold-off.",
             pixel_count);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
